// File: design/pcr_pkg.sv
// ---------------------------------------------------------------------------
// Particle contact resolver package
// Field widths, fixed-point shifts and shared types of the contact resolver.
// ---------------------------------------------------------------------------
`default_nettype none

package pcr_pkg;

  localparam int NORM_W    = 16;
  localparam int PEN_W     = 16;
  localparam int REST_W    = 9;
  localparam int MASS_W    = 16;
  localparam int TOTAL_W   = MASS_W + 1;
  localparam int TS_W      = 16;
  localparam int TS_SHIFT  = 16;
  localparam int IMP_SHIFT = 8;
  localparam int PEN_SHIFT = 12;
  localparam int BASE_W    = PEN_W - 1 + PEN_SHIFT;
  localparam int VEL_SHIFT = 28;
  localparam int POS_SHIFT = 26;

  localparam logic [TS_W-1:0] TS_RESET = 16'd1092;

  typedef struct packed {
    logic rem_v_nz;
    logic rem_p_nz;
  } div_flags_t;

endpackage

`default_nettype wire

// File: design/particle_contact_resolver_top.sv
// ---------------------------------------------------------------------------
// Particle contact resolver
// Resolves one particle contact per item: impulse on the velocities with a
// resting-contact term, then separation of interpenetrating particles.
// ---------------------------------------------------------------------------
// channel   direction  handshake                     payload
// in        input      in_valid_i / in_ready_o       contact fields, *_i
// out       output     out_valid_o / out_ready_i     resolved fields, *_o
// config    input      time_step_we_i                time_step_i
//
// One item enters per cycle unless the pipeline is stalled, and passes through six
// front stages, COMPONENT_WIDTH + 21 divider stages with one quotient bit each
// and three back stages ending in the output register.
// Every stage holds its item while the next one is full, so bubbles close up.
// Reset clears all valid bits and loads the time step with its reset value.
// ---------------------------------------------------------------------------
`default_nettype none

module particle_contact_resolver_top #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              time_step_we_i,
  input  wire logic [pcr_pkg::TS_W-1:0]          time_step_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [3*pcr_pkg::NORM_W-1:0]      contact_normal_i,
  input  wire logic signed [pcr_pkg::PEN_W-1:0]  penetration_i,
  input  wire logic [pcr_pkg::REST_W-1:0]        restitution_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]      velocity_a_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]      velocity_b_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]      accel_a_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]      accel_b_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]      position_a_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]      position_b_i,
  input  wire logic [pcr_pkg::MASS_W-1:0]        inv_mass_a_i,
  input  wire logic [pcr_pkg::MASS_W-1:0]        inv_mass_b_i,
  input  wire logic                              has_second_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [3*COMPONENT_WIDTH-1:0]           new_velocity_a_o,
  output logic [3*COMPONENT_WIDTH-1:0]           new_velocity_b_o,
  output logic [3*COMPONENT_WIDTH-1:0]           new_position_a_o,
  output logic [3*COMPONENT_WIDTH-1:0]           new_position_b_o,
  output logic                                   impulse_applied_o,
  output logic                                   moved_apart_o
);

  localparam int CW    = COMPONENT_WIDTH;
  localparam int VW    = 3 * CW;
  localparam int NRW   = pcr_pkg::NORM_W;
  localparam int N3W   = 3 * NRW;
  localparam int PW    = 4 * VW + N3W;
  localparam int DW    = CW + 1;
  localparam int PRW   = DW + NRW;
  localparam int SW    = PRW + 2;
  localparam int ATW   = SW + pcr_pkg::TS_W + 1;
  localparam int ASW   = ATW - pcr_pkg::TS_SHIFT;
  localparam int EAW   = ASW + pcr_pkg::REST_W + 1;
  localparam int NSW   = SW + pcr_pkg::REST_W;
  localparam int NUW   = NSW + 1;
  localparam int QW    = NUW - pcr_pkg::IMP_SHIFT;
  localparam int MW    = pcr_pkg::MASS_W;
  localparam int TW    = pcr_pkg::TOTAL_W;
  localparam int BW    = pcr_pkg::BASE_W;
  localparam int NUMW  = QW + MW;
  localparam int DPW   = PW + QW + BW + 3;
  localparam int PV    = QW + 1 + NRW;
  localparam int PP    = BW + 1 + NRW;
  localparam int EW    = PV + 1;
  localparam int NF    = 6;
  localparam int NB    = 3;

  localparam logic signed [PV-1:0] VHALF =
    {{(PV-pcr_pkg::VEL_SHIFT){1'b0}}, 1'b1, {(pcr_pkg::VEL_SHIFT-1){1'b0}}};
  localparam logic signed [PP-1:0] PHALF =
    {{(PP-pcr_pkg::POS_SHIFT){1'b0}}, 1'b1, {(pcr_pkg::POS_SHIFT-1){1'b0}}};

  function automatic logic [CW-1:0] sat(logic signed [EW-1:0] x);
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    hi = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return x[CW-1:0];
    end
  endfunction

  // configuration
  logic [pcr_pkg::TS_W-1:0] time_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= pcr_pkg::TS_RESET;
    end else if (time_step_we_i) begin
      time_step_q <= time_step_i;
    end
  end

  // front pipeline control
  logic [NF-1:0] vf_q;
  logic [NF-1:0] vf_d;
  logic [NF:0]   ef;
  logic          div_ready;

  assign ef[NF] = div_ready;
  for (genvar k = 0; k < NF; k++) begin : g_ef
    assign ef[k] = ~vf_q[k] | ef[k+1];
  end
  assign vf_d = (ef[NF-1:0] & {vf_q[NF-2:0], in_valid_i}) | (~ef[NF-1:0] & vf_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else begin
      vf_q <= vf_d;
    end
  end

  assign in_ready_o = ef[0];

  // stage F1: relative velocity and acceleration products
  logic signed [PRW-1:0]    f1_pv_d [3];
  logic signed [PRW-1:0]    f1_pa_d [3];
  logic signed [PRW-1:0]    f1_pv_q [3];
  logic signed [PRW-1:0]    f1_pa_q [3];
  logic [PW-1:0]            f1_pass_q;
  logic signed [pcr_pkg::PEN_W-1:0] f1_pen_q;
  logic [pcr_pkg::REST_W-1:0] f1_e_q;
  logic [MW-1:0]            f1_ma_q;
  logic [TW-1:0]            f1_total_d;
  logic [TW-1:0]            f1_total_q;
  logic                     f1_sec_q;

  for (genvar i = 0; i < 3; i++) begin : g_f1
    logic signed [NRW-1:0] nn;
    logic signed [CW-1:0]  va;
    logic signed [CW-1:0]  vb;
    logic signed [CW-1:0]  aa;
    logic signed [CW-1:0]  ab;
    logic signed [DW-1:0]  dv;
    logic signed [DW-1:0]  da;
    assign nn = contact_normal_i[i*NRW +: NRW];
    assign va = velocity_a_i[i*CW +: CW];
    assign vb = has_second_i ? velocity_b_i[i*CW +: CW] : '0;
    assign aa = accel_a_i[i*CW +: CW];
    assign ab = has_second_i ? accel_b_i[i*CW +: CW] : '0;
    assign dv = DW'(va) - DW'(vb);
    assign da = DW'(aa) - DW'(ab);
    assign f1_pv_d[i] = PRW'(nn) * PRW'(dv);
    assign f1_pa_d[i] = PRW'(nn) * PRW'(da);
  end

  assign f1_total_d = {1'b0, inv_mass_a_i} + (has_second_i ? {1'b0, inv_mass_b_i} : '0);

  always_ff @(posedge clk_i) begin
    if (ef[0]) begin
      f1_pv_q    <= f1_pv_d;
      f1_pa_q    <= f1_pa_d;
      f1_pass_q  <= {position_b_i, position_a_i, velocity_b_i, velocity_a_i, contact_normal_i};
      f1_pen_q   <= penetration_i;
      f1_e_q     <= restitution_i;
      f1_ma_q    <= inv_mass_a_i;
      f1_total_q <= f1_total_d;
      f1_sec_q   <= has_second_i;
    end
  end

  // stage F2: separating velocity and acceleration sums
  logic signed [SW-1:0] f2_sep_d;
  logic signed [SW-1:0] f2_acc_d;
  logic signed [SW-1:0] f2_sep_q;
  logic signed [SW-1:0] f2_acc_q;
  logic [PW-1:0]        f2_pass_q;
  logic signed [pcr_pkg::PEN_W-1:0] f2_pen_q;
  logic [pcr_pkg::REST_W-1:0] f2_e_q;
  logic [MW-1:0]        f2_ma_q;
  logic [TW-1:0]        f2_total_q;
  logic                 f2_sec_q;

  assign f2_sep_d = SW'(f1_pv_q[0]) + SW'(f1_pv_q[1]) + SW'(f1_pv_q[2]);
  assign f2_acc_d = SW'(f1_pa_q[0]) + SW'(f1_pa_q[1]) + SW'(f1_pa_q[2]);

  always_ff @(posedge clk_i) begin
    if (ef[1]) begin
      f2_sep_q   <= f2_sep_d;
      f2_acc_q   <= f2_acc_d;
      f2_pass_q  <= f1_pass_q;
      f2_pen_q   <= f1_pen_q;
      f2_e_q     <= f1_e_q;
      f2_ma_q    <= f1_ma_q;
      f2_total_q <= f1_total_q;
      f2_sec_q   <= f1_sec_q;
    end
  end

  // stage F3: acceleration times time step, restitution times closing speed
  logic [SW-1:0]         f3_negsep_d;
  logic [NSW-1:0]        f3_nse_d;
  logic signed [ATW-1:0] f3_accts_d;
  logic                  f3_imp_d;
  logic                  f3_pos_d;
  logic [BW-1:0]         f3_base_d;
  logic [SW-1:0]         f3_negsep_q;
  logic [NSW-1:0]        f3_nse_q;
  logic signed [ATW-1:0] f3_accts_q;
  logic                  f3_imp_q;
  logic                  f3_pos_q;
  logic [BW-1:0]         f3_base_q;
  logic [PW-1:0]         f3_pass_q;
  logic [pcr_pkg::REST_W-1:0] f3_e_q;
  logic [MW-1:0]         f3_ma_q;
  logic [TW-1:0]         f3_total_q;
  logic                  f3_sec_q;

  assign f3_negsep_d = SW'(-f2_sep_q);
  assign f3_nse_d    = NSW'(f3_negsep_d) * NSW'(f2_e_q);
  assign f3_accts_d  = ATW'(f2_acc_q) * ATW'($signed({1'b0, time_step_q}));
  assign f3_imp_d    = (f2_sep_q[SW-1] || f2_sep_q == '0) && (f2_total_q != '0);
  assign f3_pos_d    = !f2_pen_q[pcr_pkg::PEN_W-1] && (f2_pen_q != '0) && (f2_total_q != '0);
  assign f3_base_d   = {f2_pen_q[pcr_pkg::PEN_W-2:0], {pcr_pkg::PEN_SHIFT{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (ef[2]) begin
      f3_negsep_q <= f3_negsep_d;
      f3_nse_q    <= f3_nse_d;
      f3_accts_q  <= f3_accts_d;
      f3_imp_q    <= f3_imp_d;
      f3_pos_q    <= f3_pos_d;
      f3_base_q   <= f3_base_d;
      f3_pass_q   <= f2_pass_q;
      f3_e_q      <= f2_e_q;
      f3_ma_q     <= f2_ma_q;
      f3_total_q  <= f2_total_q;
      f3_sec_q    <= f2_sec_q;
    end
  end

  // stage F4: restitution times the acceleration-caused speed
  logic signed [ASW-1:0] f4_accsep;
  logic signed [EAW-1:0] f4_eacc_d;
  logic signed [EAW-1:0] f4_eacc_q;
  logic                  f4_neg_q;
  logic [SW-1:0]         f4_negsep_q;
  logic [NSW-1:0]        f4_nse_q;
  logic                  f4_imp_q;
  logic                  f4_pos_q;
  logic [BW-1:0]         f4_base_q;
  logic [PW-1:0]         f4_pass_q;
  logic [MW-1:0]         f4_ma_q;
  logic [TW-1:0]         f4_total_q;
  logic                  f4_sec_q;

  assign f4_accsep = f3_accts_q[ATW-1:pcr_pkg::TS_SHIFT];
  assign f4_eacc_d = EAW'(f4_accsep) * EAW'($signed({1'b0, f3_e_q}));

  always_ff @(posedge clk_i) begin
    if (ef[3]) begin
      f4_eacc_q   <= f4_eacc_d;
      f4_neg_q    <= f4_accsep[ASW-1];
      f4_negsep_q <= f3_negsep_q;
      f4_nse_q    <= f3_nse_q;
      f4_imp_q    <= f3_imp_q;
      f4_pos_q    <= f3_pos_q;
      f4_base_q   <= f3_base_q;
      f4_pass_q   <= f3_pass_q;
      f4_ma_q     <= f3_ma_q;
      f4_total_q  <= f3_total_q;
      f4_sec_q    <= f3_sec_q;
    end
  end

  // stage F5: clamped target speed and velocity change
  logic signed [EAW:0] f5_nsum;
  logic [NSW-1:0]      f5_ns;
  logic [NUW-1:0]      f5_num;
  logic [QW-1:0]       f5_delta_q;
  logic                f5_imp_q;
  logic                f5_pos_q;
  logic [BW-1:0]       f5_base_q;
  logic [PW-1:0]       f5_pass_q;
  logic [MW-1:0]       f5_ma_q;
  logic [TW-1:0]       f5_total_q;
  logic                f5_sec_q;

  assign f5_nsum = (EAW+1)'($signed({2'b00, f4_nse_q})) + (EAW+1)'(f4_eacc_q);
  assign f5_ns   = !f4_neg_q ? f4_nse_q : (f5_nsum[EAW] ? '0 : f5_nsum[NSW-1:0]);
  assign f5_num  = NUW'(f5_ns) + NUW'({f4_negsep_q, {pcr_pkg::IMP_SHIFT{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (ef[4]) begin
      f5_delta_q <= f5_num[NUW-1:pcr_pkg::IMP_SHIFT];
      f5_imp_q   <= f4_imp_q;
      f5_pos_q   <= f4_pos_q;
      f5_base_q  <= f4_base_q;
      f5_pass_q  <= f4_pass_q;
      f5_ma_q    <= f4_ma_q;
      f5_total_q <= f4_total_q;
      f5_sec_q   <= f4_sec_q;
    end
  end

  // stage F6: dividends scaled by the inverse mass of A
  logic [NUMW-1:0] f6_nv_q;
  logic [NUMW-1:0] f6_np_q;
  logic [QW-1:0]   f6_delta_q;
  logic            f6_imp_q;
  logic            f6_pos_q;
  logic [BW-1:0]   f6_base_q;
  logic [PW-1:0]   f6_pass_q;
  logic [TW-1:0]   f6_total_q;
  logic            f6_sec_q;

  always_ff @(posedge clk_i) begin
    if (ef[5]) begin
      f6_nv_q    <= NUMW'(f5_delta_q) * NUMW'(f5_ma_q);
      f6_np_q    <= NUMW'(f5_base_q) * NUMW'(f5_ma_q);
      f6_delta_q <= f5_delta_q;
      f6_imp_q   <= f5_imp_q;
      f6_pos_q   <= f5_pos_q;
      f6_base_q  <= f5_base_q;
      f6_pass_q  <= f5_pass_q;
      f6_total_q <= f5_total_q;
      f6_sec_q   <= f5_sec_q;
    end
  end

  // divider
  logic                 d_valid;
  logic [QW-1:0]        d_quo_v;
  logic [QW-1:0]        d_quo_p;
  pcr_pkg::div_flags_t  d_flags;
  logic [DPW-1:0]       d_pay;
  logic [NB:0]          eb;

  pcr_divider #(
    .QW   (QW),
    .PAYW (DPW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vf_q[NF-1]),
    .ready_o (div_ready),
    .num_v_i (f6_nv_q),
    .num_p_i (f6_np_q),
    .den_i   (f6_total_q),
    .pay_i   ({f6_pass_q, f6_delta_q, f6_base_q, f6_sec_q, f6_imp_q, f6_pos_q}),
    .valid_o (d_valid),
    .ready_i (eb[0]),
    .quo_v_o (d_quo_v),
    .quo_p_o (d_quo_p),
    .flags_o (d_flags),
    .pay_o   (d_pay)
  );

  logic [PW-1:0] d_pass;
  logic [QW-1:0] d_delta;
  logic [BW-1:0] d_base;
  logic          d_sec;
  logic          d_imp;
  logic          d_pos;

  assign {d_pass, d_delta, d_base, d_sec, d_imp, d_pos} = d_pay;

  // back pipeline control
  logic [NB-1:0] vb_q;
  logic [NB-1:0] vb_d;

  assign eb[NB] = out_ready_i;
  for (genvar k = 0; k < NB; k++) begin : g_eb
    assign eb[k] = ~vb_q[k] | eb[k+1];
  end
  assign vb_d = (eb[NB-1:0] & {vb_q[NB-2:0], d_valid}) | (~eb[NB-1:0] & vb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else begin
      vb_q <= vb_d;
    end
  end

  // stage B1: shares of A and B
  logic [QW-1:0] b1_qa_q;
  logic [QW-1:0] b1_qb_q;
  logic [BW-1:0] b1_mva_q;
  logic [BW-1:0] b1_mvb_q;
  logic [PW-1:0] b1_pass_q;
  logic          b1_sec_q;
  logic          b1_imp_q;
  logic          b1_pos_q;

  always_ff @(posedge clk_i) begin
    if (eb[0]) begin
      b1_qa_q   <= d_quo_v;
      b1_qb_q   <= d_delta - d_quo_v - QW'(d_flags.rem_v_nz);
      b1_mva_q  <= d_quo_p[BW-1:0];
      b1_mvb_q  <= d_base - d_quo_p[BW-1:0] - BW'(d_flags.rem_p_nz);
      b1_pass_q <= d_pass;
      b1_sec_q  <= d_sec;
      b1_imp_q  <= d_imp;
      b1_pos_q  <= d_pos;
    end
  end

  // stage B2: shares along the normal
  logic signed [PV-1:0] b2_dva_d [3];
  logic signed [PV-1:0] b2_dvb_d [3];
  logic signed [PP-1:0] b2_dpa_d [3];
  logic signed [PP-1:0] b2_dpb_d [3];
  logic signed [PV-1:0] b2_dva_q [3];
  logic signed [PV-1:0] b2_dvb_q [3];
  logic signed [PP-1:0] b2_dpa_q [3];
  logic signed [PP-1:0] b2_dpb_q [3];
  logic [PW-1:0]        b2_pass_q;
  logic                 b2_sec_q;
  logic                 b2_imp_q;
  logic                 b2_pos_q;

  for (genvar i = 0; i < 3; i++) begin : g_b2
    logic signed [NRW-1:0] nn;
    logic signed [QW:0]    qas;
    logic signed [QW:0]    qbs;
    logic signed [BW:0]    mas;
    logic signed [BW:0]    mbs;
    assign nn  = b1_pass_q[i*NRW +: NRW];
    assign qas = {1'b0, b1_qa_q};
    assign qbs = {1'b0, b1_qb_q};
    assign mas = {1'b0, b1_mva_q};
    assign mbs = {1'b0, b1_mvb_q};
    assign b2_dva_d[i] = PV'(qas) * PV'(nn);
    assign b2_dvb_d[i] = PV'(qbs) * PV'(nn);
    assign b2_dpa_d[i] = PP'(mas) * PP'(nn);
    assign b2_dpb_d[i] = PP'(mbs) * PP'(nn);
  end

  always_ff @(posedge clk_i) begin
    if (eb[1]) begin
      b2_dva_q  <= b2_dva_d;
      b2_dvb_q  <= b2_dvb_d;
      b2_dpa_q  <= b2_dpa_d;
      b2_dpb_q  <= b2_dpb_d;
      b2_pass_q <= b1_pass_q;
      b2_sec_q  <= b1_sec_q;
      b2_imp_q  <= b1_imp_q;
      b2_pos_q  <= b1_pos_q;
    end
  end

  // stage B3: round, apply, saturate
  logic [VW-1:0] b3_va_d;
  logic [VW-1:0] b3_vb_d;
  logic [VW-1:0] b3_pa_d;
  logic [VW-1:0] b3_pb_d;
  logic [VW-1:0] out_va_q;
  logic [VW-1:0] out_vb_q;
  logic [VW-1:0] out_pa_q;
  logic [VW-1:0] out_pb_q;
  logic          out_imp_q;
  logic          out_pos_q;

  for (genvar i = 0; i < 3; i++) begin : g_b3
    logic signed [CW-1:0] va;
    logic signed [CW-1:0] vb;
    logic signed [CW-1:0] pa;
    logic signed [CW-1:0] pb;
    logic signed [PV-1:0] rva;
    logic signed [PV-1:0] rvb;
    logic signed [PP-1:0] rpa;
    logic signed [PP-1:0] rpb;
    logic signed [EW-1:0] sva;
    logic signed [EW-1:0] svb;
    logic signed [EW-1:0] spa;
    logic signed [EW-1:0] spb;
    assign va  = b2_pass_q[N3W + i*CW +: CW];
    assign vb  = b2_pass_q[N3W + VW + i*CW +: CW];
    assign pa  = b2_pass_q[N3W + 2*VW + i*CW +: CW];
    assign pb  = b2_pass_q[N3W + 3*VW + i*CW +: CW];
    assign rva = (b2_dva_q[i] + VHALF) >>> pcr_pkg::VEL_SHIFT;
    assign rvb = (b2_dvb_q[i] + VHALF) >>> pcr_pkg::VEL_SHIFT;
    assign rpa = (b2_dpa_q[i] + PHALF) >>> pcr_pkg::POS_SHIFT;
    assign rpb = (b2_dpb_q[i] + PHALF) >>> pcr_pkg::POS_SHIFT;
    assign sva = EW'(va) + EW'(rva);
    assign svb = EW'(vb) - EW'(rvb);
    assign spa = EW'(pa) + EW'(rpa);
    assign spb = EW'(pb) - EW'(rpb);
    assign b3_va_d[i*CW +: CW] = b2_imp_q ? sat(sva) : va;
    assign b3_vb_d[i*CW +: CW] = (b2_imp_q && b2_sec_q) ? sat(svb) : vb;
    assign b3_pa_d[i*CW +: CW] = b2_pos_q ? sat(spa) : pa;
    assign b3_pb_d[i*CW +: CW] = (b2_pos_q && b2_sec_q) ? sat(spb) : pb;
  end

  always_ff @(posedge clk_i) begin
    if (eb[2]) begin
      out_va_q  <= b3_va_d;
      out_vb_q  <= b3_vb_d;
      out_pa_q  <= b3_pa_d;
      out_pb_q  <= b3_pb_d;
      out_imp_q <= b2_imp_q;
      out_pos_q <= b2_pos_q;
    end
  end

  assign out_valid_o       = vb_q[NB-1];
  assign new_velocity_a_o  = out_va_q;
  assign new_velocity_b_o  = out_vb_q;
  assign new_position_a_o  = out_pa_q;
  assign new_position_b_o  = out_pb_q;
  assign impulse_applied_o = out_imp_q;
  assign moved_apart_o     = out_pos_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vb_q[NB-2]))
    else $error("output item appeared without a source");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vf_q[NF-1] && !div_ready) |=> vf_q[NF-1])
    else $error("front item lost at divider entry");

endmodule

`default_nettype wire

// File: design/pcr_divider.sv
// ---------------------------------------------------------------------------
// Contact resolver divider
// Two pipelined restoring dividers sharing one divisor, one quotient bit per
// stage, with a sideband word that travels alongside each item.
// ---------------------------------------------------------------------------
`default_nettype none

module pcr_divider #(
  parameter int QW   = 37,
  parameter int PAYW = 256
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     valid_i,
  output logic                                          ready_o,
  input  wire logic [QW+pcr_pkg::MASS_W-1:0]            num_v_i,
  input  wire logic [QW+pcr_pkg::MASS_W-1:0]            num_p_i,
  input  wire logic [pcr_pkg::TOTAL_W-1:0]              den_i,
  input  wire logic [PAYW-1:0]                          pay_i,
  output logic                                          valid_o,
  input  wire logic                                     ready_i,
  output logic [QW-1:0]                                 quo_v_o,
  output logic [QW-1:0]                                 quo_p_o,
  output pcr_pkg::div_flags_t                           flags_o,
  output logic [PAYW-1:0]                               pay_o
);

  localparam int TW = pcr_pkg::TOTAL_W;

  logic [QW-1:0] v_q;
  logic [QW-1:0] v_d;
  logic [QW:0]   en;

  logic [TW-1:0]   rem_v_q [QW];
  logic [TW-1:0]   rem_p_q [QW];
  logic [QW-1:0]   qd_v_q  [QW];
  logic [QW-1:0]   qd_p_q  [QW];
  logic [TW-1:0]   den_q   [QW];
  logic [PAYW-1:0] pay_q   [QW];

  function automatic logic [TW+QW-1:0] div_step(logic [TW-1:0] rem, logic [QW-1:0] qd,
                                               logic [TW-1:0] den);
    logic [TW:0]   sh;
    logic [TW:0]   df;
    logic          qb;
    logic [TW-1:0] rn;
    sh = {rem, qd[QW-1]};
    df = sh - {1'b0, den};
    qb = (sh >= {1'b0, den});
    rn = qb ? df[TW-1:0] : sh[TW-1:0];
    return {rn, qd[QW-2:0], qb};
  endfunction

  assign en[QW] = ready_i;
  for (genvar k = 0; k < QW; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign v_d = (en[QW-1:0] & {v_q[QW-2:0], valid_i}) | (~en[QW-1:0] & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [TW-1:0]   rv_in;
    logic [TW-1:0]   rp_in;
    logic [TW-1:0]   den_in;
    logic [QW-1:0]   qv_in;
    logic [QW-1:0]   qp_in;
    logic [PAYW-1:0] pay_in;
    logic [TW+QW-1:0] sv;
    logic [TW+QW-1:0] sp;

    if (k == 0) begin : g_first
      assign rv_in  = {1'b0, num_v_i[QW+pcr_pkg::MASS_W-1:QW]};
      assign rp_in  = {1'b0, num_p_i[QW+pcr_pkg::MASS_W-1:QW]};
      assign qv_in  = num_v_i[QW-1:0];
      assign qp_in  = num_p_i[QW-1:0];
      assign den_in = den_i;
      assign pay_in = pay_i;
    end else begin : g_next
      assign rv_in  = rem_v_q[k-1];
      assign rp_in  = rem_p_q[k-1];
      assign qv_in  = qd_v_q[k-1];
      assign qp_in  = qd_p_q[k-1];
      assign den_in = den_q[k-1];
      assign pay_in = pay_q[k-1];
    end

    assign sv = div_step(rv_in, qv_in, den_in);
    assign sp = div_step(rp_in, qp_in, den_in);

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_v_q[k] <= sv[TW+QW-1:QW];
        qd_v_q[k]  <= sv[QW-1:0];
        rem_p_q[k] <= sp[TW+QW-1:QW];
        qd_p_q[k]  <= sp[QW-1:0];
        den_q[k]   <= den_in;
        pay_q[k]   <= pay_in;
      end
    end
  end

  assign ready_o          = en[0];
  assign valid_o          = v_q[QW-1];
  assign quo_v_o          = qd_v_q[QW-1];
  assign quo_p_o          = qd_p_q[QW-1];
  assign flags_o.rem_v_nz = (rem_v_q[QW-1] != '0);
  assign flags_o.rem_p_nz = (rem_p_q[QW-1] != '0);
  assign pay_o            = pay_q[QW-1];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[QW-1] && den_q[QW-1] != '0) |-> (rem_v_q[QW-1] < den_q[QW-1]))
    else $error("velocity remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[QW-1] && den_q[QW-1] != '0) |-> (rem_p_q[QW-1] < den_q[QW-1]))
    else $error("position remainder not below divisor");

endmodule

`default_nettype wire
